FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define KCL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kcl_pkg.sv
package kcl_pkg;

  localparam int unsigned ColW   = 4;
  localparam int unsigned RowW   = 2;
  localparam int unsigned TickW  = 8;
  localparam int unsigned KeyW   = 5;
  localparam int unsigned EntryW = 14;

  localparam logic [TickW-1:0]  DebounceReset = 8'd20;
  localparam logic [EntryW-1:0] CodeReset     = 14'd6789;
  localparam logic [EntryW-1:0] EntryLimit    = 14'd9999;

  localparam logic [KeyW-1:0] KeyDigitLast = 5'd10;
  localparam logic [KeyW-1:0] KeyClear     = 5'd15;
  localparam logic [KeyW-1:0] KeyEnter     = 5'd16;

  typedef enum logic [1:0] {
    CfgDebounce = 2'd0,
    CfgCode     = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StBlank = 2'd0,
    StMatch = 2'd1,
    StError = 2'd2
  } status_e;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] code;
  } key_t;

endpackage

FILE: rtl/kcl_if.sv
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink   (input valid, input column_levels, output ready);
endinterface

interface kcl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_drive;
  logic        key_event;
  logic [4:0]  key_code;
  logic [13:0] entry_value;
  logic [1:0]  lock_status;

  modport source (output valid, output row_drive, output key_event, output key_code,
                  output entry_value, output lock_status, input ready);
  modport sink   (input valid, input row_drive, input key_event, input key_code,
                  input entry_value, input lock_status, output ready);
endinterface

interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/kcl_scan.sv
module kcl_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [kcl_pkg::ColW-1:0]       cols_i,
  input  logic [kcl_pkg::TickW-1:0]      debounce_i,
  output logic [kcl_pkg::ColW-1:0]       row_drive_o,
  output kcl_pkg::key_t                  key_o
);

  typedef enum logic [1:0] {
    PhScan    = 2'd0,
    PhPress   = 2'd1,
    PhRelease = 2'd2,
    PhSettle  = 2'd3
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [kcl_pkg::RowW-1:0]     row_q, row_d;
  logic [kcl_pkg::TickW-1:0]    wait_q, wait_d;
  logic [kcl_pkg::KeyW-1:0]     held_q, held_d;
  logic [kcl_pkg::RowW-1:0]     hit_col;
  logic [kcl_pkg::KeyW-1:0]     held_m1;

  assign row_drive_o = ~(kcl_pkg::ColW'(1) << row_q);
  assign held_m1     = held_q - kcl_pkg::KeyW'(1);

  always_comb begin
    priority if (!cols_i[0]) begin
      hit_col = 2'd0;
    end else if (!cols_i[1]) begin
      hit_col = 2'd1;
    end else if (!cols_i[2]) begin
      hit_col = 2'd2;
    end else begin
      hit_col = 2'd3;
    end
  end

  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    wait_d  = wait_q;
    held_d  = held_q;
    key_o   = '0;
    if (phase_q == PhScan) begin
      if (cols_i != {kcl_pkg::ColW{1'b1}}) begin
        held_d  = {1'b0, hit_col, row_q} + kcl_pkg::KeyW'(1);
        wait_d  = debounce_i;
        phase_d = PhPress;
      end else begin
        row_d = row_q + kcl_pkg::RowW'(1);
      end
    end else begin
      if (phase_d == PhPress) begin
        if (wait_d != '0) begin
          wait_d = wait_d - kcl_pkg::TickW'(1);
        end
        if (wait_d == '0) begin
          phase_d = PhRelease;
        end
      end
      if (phase_d == PhRelease) begin
        if (cols_i[held_m1[3:2]]) begin
          wait_d  = debounce_i;
          phase_d = PhSettle;
        end
      end else if (phase_d == PhSettle) begin
        if (wait_d != '0) begin
          wait_d = wait_d - kcl_pkg::TickW'(1);
        end
      end
      if (phase_d == PhSettle && wait_d == '0) begin
        key_o.valid = 1'b1;
        key_o.code  = held_q;
        phase_d     = PhScan;
        row_d       = row_q + kcl_pkg::RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhScan;
      row_q   <= '0;
      wait_q  <= '0;
      held_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      wait_q  <= wait_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: rtl/kcl_lock.sv
module kcl_lock (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  kcl_pkg::key_t               key_i,
  input  logic [kcl_pkg::EntryW-1:0]  stored_code_i,
  output logic [kcl_pkg::EntryW-1:0]  entry_o,
  output kcl_pkg::status_e            status_o
);

  localparam int unsigned ProdW = kcl_pkg::EntryW + 4;

  logic [kcl_pkg::EntryW-1:0] entry_q, entry_d;
  kcl_pkg::status_e           status_q, status_d;
  logic [3:0]                 digit;
  logic [ProdW-1:0]           appended;

  // key 10 is the digit zero
  assign digit = (key_i.code == kcl_pkg::KeyDigitLast) ? 4'd0 : key_i.code[3:0];

  assign appended = {1'b0, entry_q, 3'b000} + {3'b000, entry_q, 1'b0}
                  + {{kcl_pkg::EntryW{1'b0}}, digit};

  always_comb begin
    entry_d  = entry_q;
    status_d = status_q;
    if (key_i.valid) begin
      priority if (key_i.code != '0 && key_i.code <= kcl_pkg::KeyDigitLast) begin
        if (appended <= ProdW'(kcl_pkg::EntryLimit)) begin
          entry_d = appended[kcl_pkg::EntryW-1:0];
        end
      end else if (key_i.code == kcl_pkg::KeyEnter) begin
        status_d = (entry_q == stored_code_i) ? kcl_pkg::StMatch : kcl_pkg::StError;
        entry_d  = '0;
      end else if (key_i.code == kcl_pkg::KeyClear) begin
        status_d = kcl_pkg::StBlank;
        entry_d  = '0;
      end else begin
        entry_d = entry_q;
      end
    end
  end

  assign entry_o  = entry_d;
  assign status_o = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= '0;
      status_q <= kcl_pkg::StBlank;
    end else if (step_i) begin
      entry_q  <= entry_d;
      status_q <= status_d;
    end
  end

endmodule

FILE: rtl/keypad_code_lock_unit.sv
// Keypad code lock: every accepted transaction on in_i is one scan tick carrying
// the sampled column lines, and yields exactly one transaction on out_o with the
// row driven during that tick, the key event and the lock state after it. A tick
// can be taken every clock cycle, passes through an input register and then a
// result register, and only backpressure on out_o slows the rate. Debounce
// waits count ticks, not clock cycles. Registers on cfg_i (0: debounce ticks,
// 1: stored code) are always ready, take effect on the next tick, and should be
// written only while no tick is in flight; other indexes are ignored.
module keypad_code_lock_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  kcl_in_if.sink           in_i,
  kcl_out_if.source        out_o,
  kcl_cfg_if.sink          cfg_i
);

  logic                          in_valid_q;
  logic [kcl_pkg::ColW-1:0]      cols_q;
  logic                          out_valid_q;
  logic                          advance;

  logic [kcl_pkg::TickW-1:0]     debounce_q;
  logic [kcl_pkg::EntryW-1:0]    code_q;

  logic [kcl_pkg::ColW-1:0]      row_drive;
  kcl_pkg::key_t                 key;
  logic [kcl_pkg::EntryW-1:0]    entry;
  kcl_pkg::status_e              status;

  logic [kcl_pkg::ColW-1:0]      row_drive_q;
  kcl_pkg::key_t                 key_q;
  logic [kcl_pkg::EntryW-1:0]    entry_q;
  kcl_pkg::status_e              status_q;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kcl_pkg::DebounceReset;
      code_q     <= kcl_pkg::CodeReset;
    end else if (cfg_i.valid) begin
      unique case (kcl_pkg::cfg_reg_e'(cfg_i.index))
        kcl_pkg::CfgDebounce: debounce_q <= cfg_i.data[kcl_pkg::TickW-1:0];
        kcl_pkg::CfgCode:     code_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cols_q <= in_i.column_levels;
    end
    if (advance) begin
      row_drive_q <= row_drive;
      key_q       <= key;
      entry_q     <= entry;
      status_q    <= status;
    end
  end

  kcl_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .cols_i      (cols_q),
    .debounce_i  (debounce_q),
    .row_drive_o (row_drive),
    .key_o       (key)
  );

  kcl_lock u_lock (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .key_i         (key),
    .stored_code_i (code_q),
    .entry_o       (entry),
    .status_o      (status)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.row_drive   = row_drive_q;
  assign out_o.key_event   = key_q.valid;
  assign out_o.key_code    = key_q.code;
  assign out_o.entry_value = entry_q;
  assign out_o.lock_status = status_q;

endmodule

FILE: rtl/kcl_check.sv
`include "assert_macros.svh"

module kcl_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  row_drive_i,
  input logic        key_event_i,
  input logic [4:0]  key_code_i,
  input logic [13:0] entry_value_i,
  input logic [1:0]  lock_status_i
);

  `KCL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(entry_value_i) && $stable(key_code_i),
    "result changed while stalled")

  `KCL_ASSERT_IMPLY(a_key_range, out_valid_i,
    key_event_i ? (key_code_i != 5'd0 && key_code_i <= 5'd16) : (key_code_i == 5'd0),
    "key code does not match event")

  `KCL_ASSERT_IMPLY(a_one_row, out_valid_i,
    $countones(~row_drive_i) == 1 && entry_value_i <= 14'd9999 && lock_status_i != 2'd3,
    "row drive or lock state out of range")

  `KCL_ASSERT_IMPLY(a_clear,
    out_valid_i && key_event_i && (key_code_i == 5'd15 || key_code_i == 5'd16),
    entry_value_i == 14'd0, "entry not cleared by clear or enter key")

endmodule

bind keypad_code_lock_unit kcl_check u_kcl_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .row_drive_i   (out_o.row_drive),
  .key_event_i   (out_o.key_event),
  .key_code_i    (out_o.key_code),
  .entry_value_i (out_o.entry_value),
  .lock_status_i (out_o.lock_status)
);

FILE: sim/kcl_lock_checker.sv
`timescale 1ns / 1ps

module kcl_lock_checker
  import kcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  kcl_in_if           in_i,
  kcl_out_if          res_i,
  kcl_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {
    PhScan,
    PhPressDebounce,
    PhAwaitRelease,
    PhReleaseDebounce
  } scan_phase_e;

  typedef struct packed {
    logic [ColW-1:0]   row_drive;
    logic              key_event;
    logic [KeyW-1:0]   key_code;
    logic [EntryW-1:0] entry_value;
    status_e           lock_status;
  } lock_tick_t;

  logic [TickW-1:0]  debounce_q;
  logic [EntryW-1:0] code_q;
  logic [RowW-1:0]   row_q;
  scan_phase_e       phase_q;
  logic [TickW-1:0]  wait_q;
  logic [KeyW-1:0]   held_q;
  logic [EntryW-1:0] entry_q;
  status_e           status_q;

  lock_tick_t tick_results_q[$];

  function automatic void apply_key(logic [KeyW-1:0] key);
    int unsigned next_entry;
    if (key >= 1 && key <= KeyDigitLast) begin
      next_entry = int'(entry_q) * 10 + int'(key % 10);
      if (next_entry <= EntryLimit) entry_q = EntryW'(next_entry);
    end else if (key == KeyEnter) begin
      status_q = (entry_q == code_q) ? StMatch : StError;
      entry_q  = '0;
    end else if (key == KeyClear) begin
      entry_q  = '0;
      status_q = StBlank;
    end
  endfunction

  function automatic lock_tick_t scan_lock(logic [ColW-1:0] cols);
    lock_tick_t res;
    logic [1:0] col;
    logic [KeyW-1:0] key_idx;
    res = '0;
    res.row_drive = ~(ColW'(1) << row_q);
    if (phase_q == PhScan) begin
      if (cols != 4'hF) begin
        if (!cols[0]) col = 2'd0;
        else if (!cols[1]) col = 2'd1;
        else if (!cols[2]) col = 2'd2;
        else col = 2'd3;
        held_q  = {1'b0, col, row_q} + 5'd1;
        wait_q  = debounce_q;
        phase_q = PhPressDebounce;
      end else begin
        row_q = row_q + 1'b1;
      end
    end else begin
      if (phase_q == PhPressDebounce) begin
        if (wait_q != 0) wait_q = wait_q - 1'b1;
        if (wait_q == 0) phase_q = PhAwaitRelease;
      end
      if (phase_q == PhAwaitRelease) begin
        key_idx = held_q - 1'b1;
        if (cols[key_idx[3:2]]) begin
          wait_q  = debounce_q;
          phase_q = PhReleaseDebounce;
        end
      end else if (phase_q == PhReleaseDebounce) begin
        if (wait_q != 0) wait_q = wait_q - 1'b1;
      end
      if (phase_q == PhReleaseDebounce && wait_q == 0) begin
        res.key_event = 1'b1;
        res.key_code  = held_q;
        apply_key(held_q);
        phase_q = PhScan;
        row_q   = row_q + 1'b1;
      end
    end
    res.entry_value = entry_q;
    res.lock_status = status_q;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count_o++;
      $display("%0t %s: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lock_tick_t exp_t;
    if (!rst_ni) begin
      debounce_q   = DebounceReset;
      code_q       = CodeReset;
      row_q        = '0;
      phase_q      = PhScan;
      wait_q       = '0;
      held_q       = '0;
      entry_q      = '0;
      status_q     = StBlank;
      tick_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgDebounce: debounce_q = cfg_i.data[TickW-1:0];
          CfgCode:     code_q = cfg_i.data;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) tick_results_q.push_back(scan_lock(in_i.column_levels));
      if (res_i.valid && res_i.ready) begin
        if (tick_results_q.size() == 0) begin
          fail_count_o++;
          $display("%0t unexpected transaction: expected none actual row %h key %0d",
                   $time, res_i.row_drive, res_i.key_code);
        end else begin
          exp_t = tick_results_q.pop_front();
          check_field("row_drive", exp_t.row_drive, res_i.row_drive);
          check_field("key_event", exp_t.key_event, res_i.key_event);
          check_field("key_code", exp_t.key_code, res_i.key_code);
          check_field("entry_value", exp_t.entry_value, res_i.entry_value);
          check_field("lock_status", exp_t.lock_status, res_i.lock_status);
        end
      end
      pending_o = tick_results_q.size();
    end
  end

endmodule

FILE: sim/keypad_code_lock_unit_tb.sv
`timescale 1ns / 1ps

module keypad_code_lock_unit_tb;
  import kcl_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned results_due;

  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned ticks_sent = 0;
  int          scan_row_trk = 0;
  int          debounce_now = DebounceReset;
  int          code_now = CodeReset;

  kcl_in_if  col_if ();
  kcl_out_if res_if ();
  kcl_cfg_if cfg_if ();

  keypad_code_lock_unit uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (col_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  kcl_lock_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (col_if),
    .res_i       (res_if),
    .cfg_i       (cfg_if),
    .fail_count_o(fail_count),
    .pending_o   (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side stalls on patterns of its own
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned n;
    res_if.ready = 1'b0;
    n = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        n++;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= (n % 3) != 0;
          2: res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= (n % 17) > 9;
        endcase
      end
    end
  end

  task automatic send_tick(input logic [3:0] cols);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        col_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    col_if.valid         <= 1'b1;
    col_if.column_levels <= cols;
    @(posedge clk);
    while (!col_if.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  task automatic idle_scan(input int n);
    repeat (n) send_tick(4'hF);
    scan_row_trk = (scan_row_trk + n) % 4;
  endtask

  // full press: align to the key's row, press, bounce, hold, release, settle
  task automatic press_key(input int key);
    int col;
    int row;
    int hold;
    logic [3:0] pat;
    col  = (key - 1) / 4;
    row  = (key - 1) % 4;
    hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
    idle_scan((row - scan_row_trk + 4) % 4);
    pat = 4'($urandom) | 4'((1 << col) - 1);
    pat[col] = 1'b0;
    send_tick(pat);
    repeat ((debounce_now > 0 ? debounce_now : 1) - 1) send_tick(4'($urandom));
    repeat (hold) begin
      pat = 4'($urandom);
      pat[col] = 1'b0;
      send_tick(pat);
    end
    pat = 4'($urandom);
    pat[col] = 1'b1;
    send_tick(pat);
    repeat (debounce_now) send_tick(4'($urandom));
    scan_row_trk = (row + 1) % 4;
  endtask

  function automatic int digit_key(input int d);
    return (d == 0) ? int'(KeyDigitLast) : d;
  endfunction

  task automatic enter_digits(input int unsigned value, input int ndigits);
    int unsigned scale;
    scale = 1;
    repeat (ndigits - 1) scale *= 10;
    repeat (ndigits) begin
      press_key(digit_key((value / scale) % 10));
      scale /= 10;
    end
  endtask

  task automatic drain_results();
    col_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CfgDebounce) debounce_now = value[TickW-1:0];
    else if (idx == CfgCode) code_now = value;
  endtask

  task automatic run_session(input logic [13:0] deb_data, input logic [13:0] code_data,
                             input int unsigned target);
    int unsigned start;
    drain_results();
    write_reg(CfgDebounce, deb_data);
    write_reg(CfgCode, code_data);
    start = ticks_sent;
    while (ticks_sent - start < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 1) && code_now <= EntryLimit) enter_digits(code_now, 4);
          else enter_digits($urandom_range(0, 999999), $urandom_range(1, 6));
          press_key(KeyEnter);
        end
        3: press_key(KeyClear);
        4: press_key($urandom_range(KeyDigitLast + 1, KeyClear - 1));
        5, 6, 8: press_key($urandom_range(1, KeyEnter));
        7: idle_scan($urandom_range(1, 7));
        default: enter_digits($urandom_range(0, 999), $urandom_range(1, 3));
      endcase
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    col_if.valid         = 1'b0;
    col_if.column_levels = 4'hF;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CfgDebounce;
    cfg_if.data          = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: default code opens the lock
    enter_digits(CodeReset, 4);
    press_key(KeyEnter);

    // zero debounce, upper data bits must be dropped
    drain_results();
    write_reg(CfgDebounce, 14'h3F00);
    write_reg(CfgCode, 14'd0);
    press_key(digit_key(0));
    press_key(KeyEnter);
    enter_digits(12345, 5);
    press_key(KeyEnter);
    for (int k = KeyDigitLast + 1; k < KeyClear; k++) press_key(k);
    press_key(KeyClear);
    drain_results();
    write_reg(CfgSpare, 14'h3FFF);
    press_key(digit_key(7));
    press_key(KeyEnter);

    run_session(14'd1, 14'd9999, 200);
    run_session(14'd2, 14'($urandom_range(0, 9999)), 200);
    run_session(14'd0, 14'($urandom_range(0, 9999)), 200);
    run_session(14'h2A03, 14'($urandom_range(0, 9999)), 200);

    // longest debounce, unreachable code
    drain_results();
    write_reg(CfgDebounce, 14'd255);
    write_reg(CfgCode, 14'h3FFF);
    press_key(KeyEnter);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/kcl_pkg.sv
rtl/kcl_if.sv
rtl/kcl_scan.sv
rtl/kcl_lock.sv
rtl/keypad_code_lock_unit.sv
rtl/kcl_check.sv
sim/kcl_lock_checker.sv
sim/keypad_code_lock_unit_tb.sv
